>>> rtl/vet_pkg.sv
// Shared types, constants and codes for the viewport easing tracker.
package vet_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int HALF_ONE     = ONE >> 1;
    localparam int THR_I        = (ONE * 5 + 50) / 100;

    localparam int SCREEN_W_DEF = 80;
    localparam int SCREEN_H_DEF = 64;

    localparam int OPC_W  = 2;
    localparam int POS_W  = 18;
    localparam int ZOOM_W = 12;
    localparam int EASE_W = 9;
    localparam int VIEW_W = 17;
    localparam int ERR_W  = POS_W + 1;
    localparam int PROD_W = EASE_W + ERR_W;
    localparam int STEP_W = PROD_W - FRAC_BITS;

    localparam logic [ZOOM_W-1:0] ZOOM_ONE = ZOOM_W'(ONE);
    localparam logic [ZOOM_W-1:0] ZOOM_MIN = ZOOM_W'(ONE >> 2);
    localparam logic [ZOOM_W-1:0] ZOOM_MAX = {ZOOM_W{1'b1}};
    localparam logic [EASE_W-1:0] EASE_ONE = EASE_W'(ONE);
    localparam logic [ERR_W-1:0]  THR      = ERR_W'(THR_I);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(HALF_ONE);
    localparam logic [VIEW_W-1:0] VIEW_MAX = {VIEW_W{1'b1}};

    typedef enum logic [OPC_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_FOCUS = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_BEGIN,
        DP_DIV_VIEW,
        DP_DIV_HALF,
        DP_SIZE,
        DP_ORIGIN,
        DP_FOCUS,
        DP_CHECK,
        DP_MUL_X,
        DP_ADD_X,
        DP_MUL_Y,
        DP_ADD_Y,
        DP_MUL_Z,
        DP_ADD_Z,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             tracking;
        logic             div_done;
        logic             out_free;
    } t_dp_stat;

    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [VIEW_W-1:0]       view_w;
        logic [VIEW_W-1:0]       view_h;
        logic [ZOOM_W-1:0]       zoom_now;
        logic                    tracking;
    } t_result;

endpackage

>>> rtl/viewport_easing_tracker_unit.sv
// Idle ticks and unused opcodes go from decode straight to the result; focus, begin and
// settling or active ticks also wait on the bit-serial divider, active ticks after easing steps.
// DW = clog2(max screen + 1) + 16 is the width of the bit-serial view divider, 23 here.
// Throughput: one request at a time; the next is accepted once the last result is registered.
// Synchronous active-low reset: zoom 1.0 centered at zero, view of full screen, not tracking.
// No memories, so no clearing pass after reset.
module viewport_easing_tracker_unit #(
    parameter int SCREEN_W = vet_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = vet_pkg::SCREEN_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // pos_x[17:0], pos_y[35:18], zoom_target[47:36], easing[56:48]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // origin_x[17:0], origin_y[35:18], view_w[52:36],
                                        // view_h[69:53], zoom_now[81:70], tracking[82]
);

    vet_pkg::t_dp_cmd  cmd;
    vet_pkg::t_dp_stat stat;
    vet_pkg::t_result  res;

    vet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vet_datapath #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (s_axis_tuser),
        .i_pos_x       ($signed(s_axis_tdata[17:0])),
        .i_pos_y       ($signed(s_axis_tdata[35:18])),
        .i_zoom_target (s_axis_tdata[47:36]),
        .i_easing      (s_axis_tdata[56:48]),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_result      (res)
    );

    assign m_axis_tdata = {5'b0, res.tracking, res.zoom_now, res.view_h, res.view_w,
                           res.origin_y, res.origin_x};

endmodule

>>> rtl/vet_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module vet_div #(
    parameter int DW = 23,
    parameter int VW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_divisor,
    input  logic [DW-1:0] i_num_a,
    input  logic [DW-1:0] i_num_b,
    output logic [DW-1:0] o_quo_a,
    output logic [DW-1:0] o_quo_b,
    output logic          o_done
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_div;
    logic [VW-1:0] r_rem [2];
    logic [DW-1:0] r_q   [2];

    logic [VW:0]   rem_sh [2];
    logic          ge     [2];
    logic [VW-1:0] n_rem  [2];
    logic [DW-1:0] n_q    [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {r_rem[l], r_q[l][DW-1]};
            ge[l]     = rem_sh[l] >= {1'b0, r_div};
            n_rem[l]  = ge[l] ? VW'(rem_sh[l] - {1'b0, r_div}) : rem_sh[l][VW-1:0];
            n_q[l]    = {r_q[l][DW-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= i_divisor;
            r_q[0]   <= i_num_a;
            r_q[1]   <= i_num_b;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= n_rem[l];
                r_q[l]   <= n_q[l];
            end
        end
    end

    assign o_quo_a = r_q[0];
    assign o_quo_b = r_q[1];
    assign o_done  = r_done;

endmodule

>>> rtl/vet_datapath.sv
// Datapath: viewport state, easing multiplier, clamp, view size and origin, result register.
module vet_datapath #(
    parameter int SCREEN_W = vet_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = vet_pkg::SCREEN_H_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vet_pkg::t_dp_cmd                       i_cmd,
    output vet_pkg::t_dp_stat                      o_stat,
    input  logic [vet_pkg::OPC_W-1:0]              i_opcode,
    input  logic signed [vet_pkg::POS_W-1:0]       i_pos_x,
    input  logic signed [vet_pkg::POS_W-1:0]       i_pos_y,
    input  logic [vet_pkg::ZOOM_W-1:0]             i_zoom_target,
    input  logic [vet_pkg::EASE_W-1:0]             i_easing,
    input  logic                                   i_m_tready,
    output logic                                   o_m_tvalid,
    output vet_pkg::t_result                       o_result
);

    localparam int F    = vet_pkg::FRAC_BITS;
    localparam int PW   = vet_pkg::POS_W;
    localparam int ZW   = vet_pkg::ZOOM_W;
    localparam int VWD  = vet_pkg::VIEW_W;
    localparam int SMAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int DW   = $clog2(SMAX + 1) + 2 * F;
    localparam int SW   = DW + 2;
    localparam int WR_I = (SCREEN_W * vet_pkg::ONE > 131071) ? 131071 : SCREEN_W * vet_pkg::ONE;
    localparam int HR_I = (SCREEN_H * vet_pkg::ONE > 131071) ? 131071 : SCREEN_H * vet_pkg::ONE;

    localparam logic [VWD-1:0] W_RST = VWD'(WR_I);
    localparam logic [VWD-1:0] H_RST = VWD'(HR_I);
    localparam logic [DW-1:0] NUM_VIEW_W = DW'(SCREEN_W) << (2 * F);
    localparam logic [DW-1:0] NUM_VIEW_H = DW'(SCREEN_H) << (2 * F);
    localparam logic [DW-1:0] NUM_HALF_W = DW'(SCREEN_W) << (2 * F - 1);
    localparam logic [DW-1:0] NUM_HALF_H = DW'(SCREEN_H) << (2 * F - 1);
    localparam logic signed [SW-1:0] HI_BASE_W = SW'((SCREEN_W - 1) * vet_pkg::ONE);
    localparam logic signed [SW-1:0] HI_BASE_H = SW'((SCREEN_H - 1) * vet_pkg::ONE);
    localparam logic signed [SW-1:0] S18_MAX = SW'((1 << (PW - 1)) - 1);
    localparam logic signed [SW-1:0] S18_MIN = SW'(-(1 << (PW - 1)));
    localparam logic signed [SW-1:0] ZMAX_S  = SW'({1'b0, vet_pkg::ZOOM_MAX});
    localparam logic signed [SW-1:0] ZONE_S  = SW'(1);

    function automatic logic signed [PW-1:0] sat18(input logic signed [SW-1:0] v);
        logic signed [PW-1:0] res;
        if (v > S18_MAX) begin
            res = S18_MAX[PW-1:0];
        end else if (v < S18_MIN) begin
            res = S18_MIN[PW-1:0];
        end else begin
            res = v[PW-1:0];
        end
        return res;
    endfunction

    function automatic logic [vet_pkg::ERR_W-1:0] mag(input logic signed [vet_pkg::ERR_W-1:0] e);
        logic signed [vet_pkg::ERR_W-1:0] neg;
        neg = -e;
        return e[vet_pkg::ERR_W-1] ? neg : e;
    endfunction

    // input request
    logic [vet_pkg::OPC_W-1:0] r_op;
    logic signed [PW-1:0]      r_px;
    logic signed [PW-1:0]      r_py;
    logic [ZW-1:0]             r_zt;
    logic [vet_pkg::EASE_W-1:0] r_ek;

    // viewport state
    logic signed [PW-1:0]       r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [ZW-1:0]              r_cur_zoom, r_tgt_zoom;
    logic [vet_pkg::EASE_W-1:0] r_ease;
    logic                       r_is_tracking;
    logic [VWD-1:0]             r_width_now, r_height_now;
    logic signed [PW-1:0]       r_left_now, r_top_now;

    // easing work registers
    logic signed [vet_pkg::ERR_W-1:0] r_dx, r_dy, r_dz;
    logic [vet_pkg::PROD_W-1:0]       r_prod;
    logic                             r_neg;

    logic             r_m_valid;
    vet_pkg::t_result r_res;

    // divider
    logic          div_start, div_half, div_done;
    logic [ZW-1:0] div_divisor;
    logic [DW-1:0] quo_a, quo_b;

    logic [ZW-1:0]              zt_c;
    logic [vet_pkg::EASE_W-1:0] ek_c;

    assign zt_c = (r_zt < vet_pkg::ZOOM_MIN) ? vet_pkg::ZOOM_MIN : r_zt;
    assign ek_c = (r_ek > vet_pkg::EASE_ONE) ? vet_pkg::EASE_ONE : r_ek;

    assign div_half    = (i_cmd.op == vet_pkg::DP_DIV_HALF);
    assign div_start   = (i_cmd.op == vet_pkg::DP_DIV_VIEW) || div_half;
    assign div_divisor = div_half ? zt_c : r_cur_zoom;

    vet_div #(
        .DW (DW),
        .VW (ZW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_divisor),
        .i_num_a   (div_half ? NUM_HALF_W : NUM_VIEW_W),
        .i_num_b   (div_half ? NUM_HALF_H : NUM_VIEW_H),
        .o_quo_a   (quo_a),
        .o_quo_b   (quo_b),
        .o_done    (div_done)
    );

    // view size from quotient
    logic [VWD-1:0] n_width, n_height;
    assign n_width  = (quo_a > DW'(vet_pkg::VIEW_MAX)) ? vet_pkg::VIEW_MAX : quo_a[VWD-1:0];
    assign n_height = (quo_b > DW'(vet_pkg::VIEW_MAX)) ? vet_pkg::VIEW_MAX : quo_b[VWD-1:0];

    // origin
    logic signed [SW-1:0] org_x, org_y;
    assign org_x = SW'(r_cur_x) - SW'({1'b0, r_width_now[VWD-1:1]});
    assign org_y = SW'(r_cur_y) - SW'({1'b0, r_height_now[VWD-1:1]});

    // focus clamp
    logic signed [SW-1:0] half_w, half_h, hi_w, hi_h, p_x, p_y, q_x, q_y, c_x, c_y;
    always_comb begin
        half_w = SW'({1'b0, quo_a});
        half_h = SW'({1'b0, quo_b});
        hi_w   = HI_BASE_W - half_w;
        hi_h   = HI_BASE_H - half_h;
        p_x    = SW'(r_px);
        p_y    = SW'(r_py);
        q_x    = (p_x > hi_w) ? hi_w : p_x;
        q_y    = (p_y > hi_h) ? hi_h : p_y;
        c_x    = (q_x < half_w) ? half_w : q_x;
        c_y    = (q_y < half_h) ? half_h : q_y;
    end

    // errors and tracking test
    logic signed [vet_pkg::ERR_W-1:0] e_x, e_y, e_z;
    logic                             n_track;
    always_comb begin
        e_x = $signed({r_tgt_x[PW-1], r_tgt_x}) - $signed({r_cur_x[PW-1], r_cur_x});
        e_y = $signed({r_tgt_y[PW-1], r_tgt_y}) - $signed({r_cur_y[PW-1], r_cur_y});
        e_z = $signed(vet_pkg::ERR_W'(r_tgt_zoom)) - $signed(vet_pkg::ERR_W'(r_cur_zoom));
        n_track = (mag(e_x) > vet_pkg::THR) || (mag(e_y) > vet_pkg::THR)
               || (mag(e_z) > vet_pkg::THR);
    end

    // shared multiplier operand
    logic signed [vet_pkg::ERR_W-1:0] e_sel;
    always_comb begin
        case (i_cmd.op)
            vet_pkg::DP_MUL_Y: e_sel = r_dy;
            vet_pkg::DP_MUL_Z: e_sel = r_dz;
            default:           e_sel = r_dx;
        endcase
    end

    // rounded eased step and new positions
    logic [vet_pkg::STEP_W-1:0] step_mag;
    logic signed [SW-1:0]       step_u, step_s, n_sum_x, n_sum_y, n_sum_z;
    logic [ZW-1:0]              n_zoom;
    always_comb begin
        step_mag = vet_pkg::STEP_W'((r_prod + vet_pkg::ROUND_HALF) >> F);
        step_u   = SW'({1'b0, step_mag});
        step_s   = r_neg ? -step_u : step_u;
        n_sum_x  = SW'(r_cur_x) + step_s;
        n_sum_y  = SW'(r_cur_y) + step_s;
        n_sum_z  = SW'({1'b0, r_cur_zoom}) + step_s;
        if (n_sum_z > ZMAX_S) begin
            n_zoom = vet_pkg::ZOOM_MAX;
        end else if (n_sum_z < ZONE_S) begin
            n_zoom = ZW'(1);
        end else begin
            n_zoom = n_sum_z[ZW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_tgt_x       <= '0;
            r_tgt_y       <= '0;
            r_cur_zoom    <= vet_pkg::ZOOM_ONE;
            r_tgt_zoom    <= vet_pkg::ZOOM_ONE;
            r_ease        <= '0;
            r_is_tracking <= 1'b0;
            r_width_now   <= W_RST;
            r_height_now  <= H_RST;
            r_left_now    <= '0;
            r_top_now     <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            case (i_cmd.op)
                vet_pkg::DP_BEGIN: begin
                    r_cur_x       <= r_px;
                    r_tgt_x       <= r_px;
                    r_cur_y       <= r_py;
                    r_tgt_y       <= r_py;
                    r_cur_zoom    <= vet_pkg::ZOOM_ONE;
                    r_tgt_zoom    <= vet_pkg::ZOOM_ONE;
                    r_is_tracking <= 1'b0;
                end
                vet_pkg::DP_FOCUS: begin
                    r_tgt_x       <= sat18(c_x);
                    r_tgt_y       <= sat18(c_y);
                    r_tgt_zoom    <= zt_c;
                    r_ease        <= ek_c;
                    r_is_tracking <= 1'b1;
                end
                vet_pkg::DP_CHECK: begin
                    r_is_tracking <= n_track;
                    if (!n_track) begin
                        r_cur_x    <= r_tgt_x;
                        r_cur_y    <= r_tgt_y;
                        r_cur_zoom <= r_tgt_zoom;
                    end
                end
                vet_pkg::DP_ADD_X: r_cur_x    <= sat18(n_sum_x);
                vet_pkg::DP_ADD_Y: r_cur_y    <= sat18(n_sum_y);
                vet_pkg::DP_ADD_Z: r_cur_zoom <= n_zoom;
                vet_pkg::DP_SIZE: begin
                    r_width_now  <= n_width;
                    r_height_now <= n_height;
                end
                vet_pkg::DP_ORIGIN: begin
                    r_left_now <= sat18(org_x);
                    r_top_now  <= sat18(org_y);
                end
                default: ;
            endcase
            if (i_cmd.op == vet_pkg::DP_OUT) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            vet_pkg::DP_LOAD: begin
                r_op <= i_opcode;
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_zt <= i_zoom_target;
                r_ek <= i_easing;
            end
            vet_pkg::DP_CHECK: begin
                r_dx <= e_x;
                r_dy <= e_y;
                r_dz <= e_z;
            end
            vet_pkg::DP_MUL_X, vet_pkg::DP_MUL_Y, vet_pkg::DP_MUL_Z: begin
                r_prod <= r_ease * mag(e_sel);
                r_neg  <= e_sel[vet_pkg::ERR_W-1];
            end
            vet_pkg::DP_OUT: begin
                r_res.origin_x <= r_left_now;
                r_res.origin_y <= r_top_now;
                r_res.view_w   <= r_width_now;
                r_res.view_h   <= r_height_now;
                r_res.zoom_now <= r_cur_zoom;
                r_res.tracking <= r_is_tracking;
            end
            default: ;
        endcase
    end

    assign o_stat.opcode   = r_op;
    assign o_stat.tracking = r_is_tracking;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_m_valid || i_m_tready;
    assign o_m_tvalid      = r_m_valid;
    assign o_result        = r_res;

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vet_pkg::DP_OUT) |=> r_m_valid)
        else $error("result register not loaded");

    a_zoom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_zoom != '0)
        else $error("current zoom reached zero");

    a_track_by_focus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_is_tracking) |-> $past(i_cmd.op == vet_pkg::DP_FOCUS))
        else $error("tracking started without a focus request");

    a_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vet_pkg::DP_CHECK) ##1 !r_is_tracking |->
        (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y) && (r_cur_zoom == r_tgt_zoom))
        else $error("settled view not snapped to target");

endmodule

>>> rtl/vet_ctrl.sv
// Controller: sequences decode, divide, easing steps and result hand-off.
module vet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  vet_pkg::t_dp_stat i_stat,
    output vet_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_STEP_SEL,
        S_MUL_X,
        S_ADD_X,
        S_MUL_Y,
        S_ADD_Y,
        S_MUL_Z,
        S_ADD_Z,
        S_DIV_VIEW,
        S_WAIT_VIEW,
        S_SIZE,
        S_ORIGIN,
        S_WAIT_HALF,
        S_FOCUS,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = vet_pkg::DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = vet_pkg::DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.opcode)
                    vet_pkg::OP_BEGIN: begin
                        o_cmd.op = vet_pkg::DP_BEGIN;
                        n_state  = S_DIV_VIEW;
                    end
                    vet_pkg::OP_FOCUS: begin
                        o_cmd.op = vet_pkg::DP_DIV_HALF;
                        n_state  = S_WAIT_HALF;
                    end
                    vet_pkg::OP_TICK: begin
                        if (i_stat.tracking) begin
                            o_cmd.op = vet_pkg::DP_CHECK;
                            n_state  = S_STEP_SEL;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_STEP_SEL: n_state = i_stat.tracking ? S_MUL_X : S_DIV_VIEW;
            S_MUL_X: begin
                o_cmd.op = vet_pkg::DP_MUL_X;
                n_state  = S_ADD_X;
            end
            S_ADD_X: begin
                o_cmd.op = vet_pkg::DP_ADD_X;
                n_state  = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.op = vet_pkg::DP_MUL_Y;
                n_state  = S_ADD_Y;
            end
            S_ADD_Y: begin
                o_cmd.op = vet_pkg::DP_ADD_Y;
                n_state  = S_MUL_Z;
            end
            S_MUL_Z: begin
                o_cmd.op = vet_pkg::DP_MUL_Z;
                n_state  = S_ADD_Z;
            end
            S_ADD_Z: begin
                o_cmd.op = vet_pkg::DP_ADD_Z;
                n_state  = S_DIV_VIEW;
            end
            S_DIV_VIEW: begin
                o_cmd.op = vet_pkg::DP_DIV_VIEW;
                n_state  = S_WAIT_VIEW;
            end
            S_WAIT_VIEW: begin
                if (i_stat.div_done) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.op = vet_pkg::DP_SIZE;
                n_state  = S_ORIGIN;
            end
            S_ORIGIN: begin
                o_cmd.op = vet_pkg::DP_ORIGIN;
                n_state  = S_OUT;
            end
            S_WAIT_HALF: begin
                if (i_stat.div_done) begin
                    n_state = S_FOCUS;
                end
            end
            S_FOCUS: begin
                o_cmd.op = vet_pkg::DP_FOCUS;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = vet_pkg::DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the viewport easing tracker: directed cases, then random easing runs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCR_W = vet_pkg::SCREEN_W_DEF;
    localparam int SCR_H = vet_pkg::SCREEN_H_DEF;
    localparam logic [vet_pkg::OPC_W-1:0] OP_SPARE = 2'd3;
    localparam longint POS_HI = (longint'(1) << (vet_pkg::POS_W - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // pos_x[17:0], pos_y[35:18], zoom_target[47:36], easing[56:48]
    logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;        // origin_x[17:0], origin_y[35:18], view_w[52:36],
                                      // view_h[69:53], zoom_now[81:70], tracking[82]

    int src_idle_pct = 34;
    int sink_idle_pct = 57;
    int cycles = 0;
    int faults = 0;
    int requests_sent = 0;
    int useful_sent = 0;
    int results_seen = 0;
    int settled_count = 0;

    vet_pkg::t_result expected_views[$];

    logic signed [vet_pkg::POS_W-1:0] view_cx, view_cy, aim_x, aim_y, edge_l, edge_t;
    logic [vet_pkg::ZOOM_W-1:0]       view_zoom, aim_zoom;
    logic [vet_pkg::EASE_W-1:0]       glide_k;
    logic                             easing_on;
    logic [vet_pkg::VIEW_W-1:0]       span_w, span_h;

    viewport_easing_tracker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_views.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint clip_pos(longint v);
        return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
    endfunction

    function automatic longint clip_unsigned(longint v, longint hi);
        return v > hi ? hi : (v < 0 ? 0 : v);
    endfunction

    function automatic longint span_of(longint screen, longint zoom);
        return clip_unsigned((screen << (2 * vet_pkg::FRAC_BITS)) / (zoom > 0 ? zoom : 1),
                             longint'(vet_pkg::VIEW_MAX));
    endfunction

    function automatic longint ease_delta(longint k, longint err);
        longint prod;
        prod = k * err;
        if (prod >= 0) return (prod + vet_pkg::HALF_ONE) >> vet_pkg::FRAC_BITS;
        return -((vet_pkg::HALF_ONE - prod) >> vet_pkg::FRAC_BITS);
    endfunction

    function automatic longint clamp_center(longint p, longint screen, longint zoom);
        longint half, hi;
        half = (screen << (2 * vet_pkg::FRAC_BITS - 1)) / zoom;
        hi = (screen - 1) * vet_pkg::ONE - half;
        if (p > hi) p = hi;
        if (p < half) p = half;
        return clip_pos(p);
    endfunction

    function automatic void refresh_view();
        span_w = vet_pkg::VIEW_W'(span_of(SCR_W, longint'(view_zoom)));
        span_h = vet_pkg::VIEW_W'(span_of(SCR_H, longint'(view_zoom)));
        edge_l = vet_pkg::POS_W'(clip_pos(longint'(view_cx) - (longint'(span_w) >> 1)));
        edge_t = vet_pkg::POS_W'(clip_pos(longint'(view_cy) - (longint'(span_h) >> 1)));
    endfunction

    function automatic vet_pkg::t_result advance_viewport(
        input logic [vet_pkg::OPC_W-1:0] op,
        input logic signed [vet_pkg::POS_W-1:0] px, py,
        input logic [vet_pkg::ZOOM_W-1:0] zt,
        input logic [vet_pkg::EASE_W-1:0] ek);
        vet_pkg::t_result view;
        longint dx, dy, dz, nz;
        logic [vet_pkg::ZOOM_W-1:0] zsel;
        case (op)
            vet_pkg::OP_BEGIN: begin
                view_cx = px;
                view_cy = py;
                aim_x = px;
                aim_y = py;
                view_zoom = vet_pkg::ZOOM_ONE;
                aim_zoom = vet_pkg::ZOOM_ONE;
                easing_on = 1'b0;
                refresh_view();
                useful_sent++;
            end
            vet_pkg::OP_FOCUS: begin
                zsel = (zt < vet_pkg::ZOOM_MIN) ? vet_pkg::ZOOM_MIN : zt;
                aim_x = vet_pkg::POS_W'(clamp_center(longint'(px), SCR_W, longint'(zsel)));
                aim_y = vet_pkg::POS_W'(clamp_center(longint'(py), SCR_H, longint'(zsel)));
                aim_zoom = zsel;
                glide_k = (ek > vet_pkg::EASE_ONE) ? vet_pkg::EASE_ONE : ek;
                easing_on = 1'b1;
                useful_sent++;
            end
            vet_pkg::OP_TICK: begin
                if (easing_on) begin
                    dx = longint'(aim_x) - longint'(view_cx);
                    dy = longint'(aim_y) - longint'(view_cy);
                    dz = longint'(aim_zoom) - longint'(view_zoom);
                    easing_on = (dx > vet_pkg::THR_I || dx < -vet_pkg::THR_I) ||
                                (dy > vet_pkg::THR_I || dy < -vet_pkg::THR_I) ||
                                (dz > vet_pkg::THR_I || dz < -vet_pkg::THR_I);
                    if (easing_on) begin
                        view_cx = vet_pkg::POS_W'(clip_pos(longint'(view_cx) +
                                                  ease_delta(longint'(glide_k), dx)));
                        view_cy = vet_pkg::POS_W'(clip_pos(longint'(view_cy) +
                                                  ease_delta(longint'(glide_k), dy)));
                        nz = clip_unsigned(longint'(view_zoom) +
                                           ease_delta(longint'(glide_k), dz),
                                           longint'(vet_pkg::ZOOM_MAX));
                        view_zoom = vet_pkg::ZOOM_W'((nz < 1) ? 1 : nz);
                    end else begin
                        view_cx = aim_x;
                        view_cy = aim_y;
                        view_zoom = aim_zoom;
                        settled_count++;
                    end
                    refresh_view();
                    useful_sent++;
                end
            end
            default: ;
        endcase
        view.origin_x = edge_l;
        view.origin_y = edge_t;
        view.view_w = span_w;
        view.view_h = span_h;
        view.zoom_now = view_zoom;
        view.tracking = easing_on;
        return view;
    endfunction

    always @(posedge i_clk) begin
        vet_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.origin_x = m_axis_tdata[17:0];
            got.origin_y = m_axis_tdata[35:18];
            got.view_w = m_axis_tdata[52:36];
            got.view_h = m_axis_tdata[69:53];
            got.zoom_now = m_axis_tdata[81:70];
            got.tracking = m_axis_tdata[82];
            results_seen++;
            if (expected_views.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("cycle %0d: result with no request pending, data %h",
                             cycles, m_axis_tdata);
            end else begin
                want = expected_views.pop_front();
                if (got.origin_x !== want.origin_x || got.origin_y !== want.origin_y ||
                    got.view_w !== want.view_w || got.view_h !== want.view_h ||
                    got.zoom_now !== want.zoom_now || got.tracking !== want.tracking) begin
                    faults++;
                    if (faults <= 10) begin
                        $display({"cycle %0d: mismatch, expected org %0d,%0d view %0d x %0d",
                                  " zoom %0d trk %0d"},
                                 cycles, want.origin_x, want.origin_y, want.view_w,
                                 want.view_h, want.zoom_now, want.tracking);
                        $display("            actual   org %0d,%0d view %0d x %0d zoom %0d trk %0d",
                                 got.origin_x, got.origin_y, got.view_w, got.view_h,
                                 got.zoom_now, got.tracking);
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [vet_pkg::OPC_W-1:0] op,
                                input logic [vet_pkg::POS_W-1:0] px, py,
                                input logic [vet_pkg::ZOOM_W-1:0] zt,
                                input logic [vet_pkg::EASE_W-1:0] ek);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, ek, zt, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_views.push_back(advance_viewport(op, px, py, zt, ek));
        requests_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_views.size() != 0);
    endtask

    function automatic logic [vet_pkg::POS_W-1:0] aim_coord(input int screen);
        if ($urandom_range(1) != 0) return vet_pkg::POS_W'($urandom);
        return vet_pkg::POS_W'($urandom_range(0, screen * vet_pkg::ONE));
    endfunction

    function automatic logic [vet_pkg::ZOOM_W-1:0] pick_zoom();
        int r;
        r = $urandom_range(99);
        if (r < 50) return vet_pkg::ZOOM_W'($urandom_range(64, 1024));
        if (r < 80) return vet_pkg::ZOOM_W'($urandom_range(64, 4095));
        return vet_pkg::ZOOM_W'($urandom);
    endfunction

    function automatic logic [vet_pkg::EASE_W-1:0] pick_easing();
        if ($urandom_range(99) < 85) return vet_pkg::EASE_W'($urandom_range(48, 256));
        return vet_pkg::EASE_W'($urandom);
    endfunction

    task automatic test_idle_reports();
        send_request(vet_pkg::OP_TICK, '0, '0, '0, '0);
        send_request(OP_SPARE, '1, '1, '1, '1);
    endtask

    task automatic test_begin_extremes();
        send_request(vet_pkg::OP_BEGIN, 18'h1FFFF, 18'h1FFFF, '1, '1);
        send_request(OP_SPARE, '0, '0, '0, '0);
        send_request(vet_pkg::OP_BEGIN, 18'h20000, 18'h20000, '0, '0);
        send_request(vet_pkg::OP_TICK, '1, '1, '1, '1);
    endtask

    task automatic test_focus_special();
        send_request(vet_pkg::OP_BEGIN, '0, '0, '0, '0);
        // zoom below the floor, easing above one, target past the right and bottom edge
        send_request(vet_pkg::OP_FOCUS, 18'h1FFFF, 18'h1FFFF, '0, 9'h1FF);
        repeat (3) send_request(vet_pkg::OP_TICK, '0, '0, '0, '0);
        send_request(vet_pkg::OP_FOCUS, 18'h20000, 18'h20000, 12'hFFF,
                     vet_pkg::EASE_W'(vet_pkg::ONE));
        repeat (2) send_request(vet_pkg::OP_TICK, '0, '0, '0, '0);
        send_request(vet_pkg::OP_FOCUS, vet_pkg::POS_W'(10240), vet_pkg::POS_W'(8192),
                     12'd300, 9'd128);
        send_request(OP_SPARE, '0, '0, '0, '0);
        repeat (3) send_request(vet_pkg::OP_TICK, '0, '0, '0, '0);
    endtask

    task automatic test_stalled_easing();
        send_request(vet_pkg::OP_FOCUS, vet_pkg::POS_W'(5000), vet_pkg::POS_W'(5000),
                     12'd512, '0);
        repeat (2) send_request(vet_pkg::OP_TICK, '0, '0, '0, '0);
        // begin drops tracking but keeps the easing factor
        send_request(vet_pkg::OP_BEGIN, vet_pkg::POS_W'(100), -vet_pkg::POS_W'(100), '0, '0);
        send_request(vet_pkg::OP_TICK, '0, '0, '0, '0);
    endtask

    task automatic test_random_tracking(input int src_pct, input int sink_pct, input int quota);
        int goal, ticks, r;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        goal = useful_sent + quota;
        while (useful_sent < goal) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_request(vet_pkg::OP_BEGIN, aim_coord(SCR_W), aim_coord(SCR_H),
                             vet_pkg::ZOOM_W'($urandom), vet_pkg::EASE_W'($urandom));
            end else if (r < 85) begin
                send_request(vet_pkg::OP_FOCUS, aim_coord(SCR_W), aim_coord(SCR_H),
                             pick_zoom(), pick_easing());
                ticks = $urandom_range(1, 60);
                while (easing_on && ticks > 0) begin
                    r = $urandom_range(99);
                    if (r < 3)
                        send_request(OP_SPARE, vet_pkg::POS_W'($urandom),
                                     vet_pkg::POS_W'($urandom),
                                     vet_pkg::ZOOM_W'($urandom), vet_pkg::EASE_W'($urandom));
                    else if (r < 6)
                        send_request(vet_pkg::OP_FOCUS, aim_coord(SCR_W), aim_coord(SCR_H),
                                     pick_zoom(), pick_easing());
                    else
                        send_request(vet_pkg::OP_TICK, vet_pkg::POS_W'($urandom),
                                     vet_pkg::POS_W'($urandom),
                                     vet_pkg::ZOOM_W'($urandom), vet_pkg::EASE_W'($urandom));
                    ticks--;
                end
            end else begin
                case ($urandom_range(2))
                    0: send_request(OP_SPARE, vet_pkg::POS_W'($urandom),
                                    vet_pkg::POS_W'($urandom),
                                    vet_pkg::ZOOM_W'($urandom), vet_pkg::EASE_W'($urandom));
                    1: send_request(vet_pkg::OP_TICK, vet_pkg::POS_W'($urandom),
                                    vet_pkg::POS_W'($urandom),
                                    vet_pkg::ZOOM_W'($urandom), vet_pkg::EASE_W'($urandom));
                    default: send_request(vet_pkg::OP_FOCUS, aim_coord(SCR_W),
                                          aim_coord(SCR_H), pick_zoom(), '0);
                endcase
            end
        end
    endtask

    initial begin
        view_cx = '0;
        view_cy = '0;
        aim_x = '0;
        aim_y = '0;
        edge_l = '0;
        edge_t = '0;
        view_zoom = vet_pkg::ZOOM_ONE;
        aim_zoom = vet_pkg::ZOOM_ONE;
        glide_k = '0;
        easing_on = 1'b0;
        span_w = vet_pkg::VIEW_W'(clip_unsigned(longint'(SCR_W) * 256,
                                                longint'(vet_pkg::VIEW_MAX)));
        span_h = vet_pkg::VIEW_W'(clip_unsigned(longint'(SCR_H) * 256,
                                                longint'(vet_pkg::VIEW_MAX)));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_reports();
        test_begin_extremes();
        test_focus_special();
        test_stalled_easing();
        test_random_tracking(34, 57, 560);
        hold_until_drained();
        test_random_tracking(57, 34, 560);
        hold_until_drained();
        test_random_tracking(0, 0, 560);
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d requests (%0d begin, focus or easing steps), %0d views checked",
                 requests_sent, useful_sent, results_seen);
        $display("easing runs settled on target: %0d, failures: %0d", settled_count, faults);
        if (faults == 0 && expected_views.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
